// File: rtl/core/dwnhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwnhs_pkg
// Shared types and constants of the delay-weighted next-hop selector.
// ----------------------------------------------------------------------------
package dwnhs_pkg;

	localparam int MAX_FACES_DEF    = 16;
	localparam int FACE_ID_BITS_DEF = 16;
	localparam int FACE_W           = 16;
	localparam int DELAY_W          = 16;
	localparam int RND_W            = 36;
	localparam int TOTAL_W          = 32;
	localparam int OUTCOME_W        = 4;

	typedef enum logic [1:0] {
		FUNC_LIST   = 2'd0,
		FUNC_SELECT = 2'd1,
		FUNC_REPORT = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_KEPT      = 4'd0,
		OUT_ADDED     = 4'd1,
		OUT_FULL      = 4'd2,
		OUT_FORWARDED = 4'd3,
		OUT_REJECTED  = 4'd4,
		OUT_IGNORED   = 4'd5,
		OUT_RECORDED  = 4'd6,
		OUT_UNKNOWN   = 4'd7,
		OUT_NO_TIMING = 4'd8
	} outcome_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [FACE_W-1:0]  face_id;
		logic               may_forward;
		logic               not_new;
		logic               timing_known;
		logic [DELAY_W-1:0] delay_ms;
		logic [RND_W-1:0]   random_value;
	} req_t;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [FACE_W-1:0]    chosen_face;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/dwnhs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwnhs_req_if / dwnhs_rsp_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface dwnhs_req_if;
	logic           valid;
	logic           ready;
	dwnhs_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dwnhs_rsp_if;
	logic           valid;
	logic           ready;
	dwnhs_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/delay_weighted_next_hop_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delay_weighted_next_hop_selector
// Next-hop table with inverse-delay weighted random face choice.
// ----------------------------------------------------------------------------
// One item at a time. Face id and delay per slot live in a one-port-read
// synchronous memory with a registered read; valid/seen/permitted bits and
// the delay total are flops. A list or report scans the memory for a match.
// A select prunes, then picks the next face in (delay, id) order by a full
// memory scan per position; an early match ends the walk. Ignored and
// no-timing items answer in the cycle after acceptance. The result sits in
// an output register and is held until taken.
module delay_weighted_next_hop_selector #(
	parameter int MAX_FACES    = dwnhs_pkg::MAX_FACES_DEF,
	parameter int FACE_ID_BITS = dwnhs_pkg::FACE_ID_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dwnhs_req_if.sink    req,
	dwnhs_rsp_if.source  rsp
);
	localparam int IW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int CW = $clog2(MAX_FACES + 1);
	localparam int KW = 64 - FACE_ID_BITS;
	localparam int SW = dwnhs_pkg::DELAY_W + dwnhs_pkg::FACE_W;
	localparam int AW = dwnhs_pkg::TOTAL_W + IW + 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_LIST  = 6'b000100,
		ST_WALK  = 6'b001000,
		ST_PICK  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// face/delay memory
	logic [dwnhs_pkg::FACE_W-1:0]  mem_face  [MAX_FACES];
	logic [dwnhs_pkg::DELAY_W-1:0] mem_delay [MAX_FACES];
	logic [IW-1:0]                 rd_addr;
	logic [dwnhs_pkg::FACE_W-1:0]  rd_face_s1;
	logic [dwnhs_pkg::DELAY_W-1:0] rd_delay_s1;
	logic                          wr_en;
	logic [IW-1:0]                 wr_addr;
	logic [dwnhs_pkg::FACE_W-1:0]  wr_face;
	logic [dwnhs_pkg::DELAY_W-1:0] wr_delay;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_face[wr_addr]  <= wr_face;
			mem_delay[wr_addr] <= wr_delay;
		end
		rd_face_s1  <= mem_face[rd_addr];
		rd_delay_s1 <= mem_delay[rd_addr];
	end

	state_t                        state_q;
	dwnhs_pkg::req_t               req_q;
	logic [MAX_FACES-1:0]          valid_q, seen_q, perm_q, used_q;
	logic [MAX_FACES-1:0]          perm_sel_q;
	logic [dwnhs_pkg::TOTAL_W-1:0] total_q;
	logic [CW-1:0]                 cnt_q;
	logic [IW-1:0]                 idx_s1;
	logic                          rd_v_s1;
	logic                          hit_q;
	logic [IW-1:0]                 hit_idx_q;
	logic [dwnhs_pkg::DELAY_W-1:0] hit_delay_q;
	// best candidate of current walk scan
	logic                          best_v_q;
	logic [IW-1:0]                 best_idx_q;
	logic [SW-1:0]                 best_key_q;
	logic [AW-1:0]                 cum_q;
	dwnhs_pkg::rsp_t               rsp_q;
	logic                          rsp_v_q;

	logic [dwnhs_pkg::FACE_W-1:0] masked_id;
	assign masked_id = dwnhs_pkg::FACE_W'(
		(64'(req_q.face_id) << KW) >> KW);

	logic [SW-1:0] rd_key;
	assign rd_key = {rd_delay_s1, rd_face_s1};

	logic          scan_done;
	assign scan_done = (cnt_q == CW'(MAX_FACES));
	assign rd_addr = cnt_q[IW-1:0];

	// first free slot
	logic          free_v;
	logic [IW-1:0] free_idx;
	always_comb begin
		free_v   = 1'b0;
		free_idx = '0;
		for (int i = MAX_FACES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_v   = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// weight of picked face and next cumulative sum
	logic [AW-1:0] weight, cum_next;
	logic [dwnhs_pkg::DELAY_W-1:0] best_delay;
	assign best_delay = best_key_q[SW-1 -: dwnhs_pkg::DELAY_W];
	assign weight = (total_q >= dwnhs_pkg::TOTAL_W'(best_delay)) ?
		AW'(total_q - dwnhs_pkg::TOTAL_W'(best_delay)) : '0;
	assign cum_next = cum_q + weight;

	// report: new total with clamp
	logic [dwnhs_pkg::TOTAL_W:0] tsum, tnew;
	always_comb begin
		tsum = {1'b0, total_q} + (dwnhs_pkg::TOTAL_W + 1)'(req_q.delay_ms);
		if (tsum >= (dwnhs_pkg::TOTAL_W + 1)'(hit_delay_q))
			tnew = tsum - (dwnhs_pkg::TOTAL_W + 1)'(hit_delay_q);
		else
			tnew = '0;
		if (tnew[dwnhs_pkg::TOTAL_W])
			tnew = {1'b0, {dwnhs_pkg::TOTAL_W{1'b1}}};
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = free_idx;
		wr_face  = masked_id;
		wr_delay = '0;
		if (state_q == ST_LIST) begin
			if (req_q.func == dwnhs_pkg::FUNC_REPORT) begin
				wr_en    = hit_q;
				wr_addr  = hit_idx_q;
				wr_delay = req_q.delay_ms;
			end else begin
				wr_en = !hit_q && free_v;
			end
		end
	end

	assign req.ready  = (state_q == ST_IDLE) && !rsp_v_q;
	assign rsp.valid  = rsp_v_q;
	assign rsp.data   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			seen_q   <= '0;
			perm_q   <= '0;
			used_q   <= '0;
			total_q  <= '0;
			cnt_q    <= '0;
			rd_v_s1  <= 1'b0;
			hit_q    <= 1'b0;
			best_v_q <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			if (rsp_v_q && rsp.ready)
				rsp_v_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q    <= req.data;
						cnt_q    <= '0;
						hit_q    <= 1'b0;
						best_v_q <= 1'b0;
						cum_q    <= '0;
						used_q   <= '0;
						unique case (dwnhs_pkg::func_t'(req.data.func))
							dwnhs_pkg::FUNC_LIST: state_q <= ST_SCAN;
							dwnhs_pkg::FUNC_REPORT: begin
								if (req.data.timing_known) begin
									state_q <= ST_SCAN;
								end else begin
									rsp_q   <= '{dwnhs_pkg::OUT_NO_TIMING, '0};
									rsp_v_q <= 1'b1;
								end
							end
							dwnhs_pkg::FUNC_SELECT: begin
								seen_q <= '0;
								perm_q <= '0;
								if (req.data.not_new) begin
									rsp_q   <= '{dwnhs_pkg::OUT_IGNORED, '0};
									rsp_v_q <= 1'b1;
								end else begin
									valid_q <= valid_q & seen_q;
									state_q <= ST_WALK;
								end
							end
							default: begin
								rsp_q   <= '{dwnhs_pkg::OUT_IGNORED, '0};
								rsp_v_q <= 1'b1;
							end
						endcase
					end
				end
				// memory scan: match search (list/report) or next-best search (walk)
				ST_SCAN, ST_WALK: begin
					if (!scan_done) begin
						cnt_q   <= cnt_q + 1'b1;
						rd_v_s1 <= 1'b1;
						idx_s1  <= cnt_q[IW-1:0];
					end
					if (rd_v_s1 && valid_q[idx_s1]) begin
						if (state_q == ST_SCAN) begin
							if (rd_face_s1 == masked_id && !hit_q) begin
								hit_q       <= 1'b1;
								hit_idx_q   <= idx_s1;
								hit_delay_q <= rd_delay_s1;
							end
						end else if (!used_q[idx_s1] &&
							(!best_v_q || rd_key < best_key_q)) begin
							best_v_q   <= 1'b1;
							best_idx_q <= idx_s1;
							best_key_q <= rd_key;
						end
					end
					if (scan_done && !rd_v_s1)
						state_q <= (state_q == ST_SCAN) ? ST_LIST : ST_PICK;
				end
				ST_LIST: begin
					state_q <= ST_OUT;
					if (req_q.func == dwnhs_pkg::FUNC_REPORT) begin
						if (hit_q) begin
							total_q <= tnew[dwnhs_pkg::TOTAL_W-1:0];
							rsp_q   <= '{dwnhs_pkg::OUT_RECORDED, '0};
						end else begin
							rsp_q   <= '{dwnhs_pkg::OUT_UNKNOWN, '0};
						end
					end else if (hit_q) begin
						seen_q[hit_idx_q] <= 1'b1;
						perm_q[hit_idx_q] <= req_q.may_forward;
						rsp_q <= '{dwnhs_pkg::OUT_KEPT, '0};
					end else if (free_v) begin
						valid_q[free_idx] <= 1'b1;
						seen_q[free_idx]  <= 1'b1;
						perm_q[free_idx]  <= req_q.may_forward;
						rsp_q <= '{dwnhs_pkg::OUT_ADDED, '0};
					end else begin
						rsp_q <= '{dwnhs_pkg::OUT_FULL, '0};
					end
				end
				// evaluate next face in order; perm_q was cleared, use saved copy
				ST_PICK: begin
					if (!best_v_q) begin
						rsp_q   <= '{dwnhs_pkg::OUT_REJECTED, '0};
						state_q <= ST_OUT;
					end else begin
						cum_q              <= cum_next;
						used_q[best_idx_q] <= 1'b1;
						if (AW'(req_q.random_value) <= cum_next
							&& perm_sel_q[best_idx_q]) begin
							rsp_q <= '{dwnhs_pkg::OUT_FORWARDED,
								best_key_q[dwnhs_pkg::FACE_W-1:0]};
							state_q <= ST_OUT;
						end else begin
							cnt_q    <= '0;
							best_v_q <= 1'b0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_OUT: begin
					rsp_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// permitted bits captured at select, used during the walk
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid && req.ready)
			perm_sel_q <= perm_q;
	end

endmodule

`default_nettype wire
